/* rtl/core/ooef_pkg.sv */
`default_nettype none

package ooef_pkg;

  // Storage geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Payload widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DATA_W = 32;

  // Configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned REG_IDX_W  = ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAPACITY_LIMIT = 1'd0
  } reg_idx_e;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

/* rtl/core/ooef_if.sv */
`default_nettype none

// Command beat: one push, pop or front read
interface ooef_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [ooef_pkg::CMD_W-1:0]    cmd;
  logic [ooef_pkg::DATA_W-1:0]   value_in;

  modport source (output valid, output cmd, output value_in, input ready);
  modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

// Status beat: queue state after one command
interface ooef_status_if;
  logic                          valid;
  logic                          ready;
  logic [ooef_pkg::DATA_W-1:0]   front_value;
  logic [ooef_pkg::CNT_W-1:0]    entry_count;
  logic                          dropped_oldest;
  logic                          is_empty;

  modport source (output valid, output front_value, output entry_count,
                  output dropped_oldest, output is_empty, input ready);
  modport sink   (input valid, input front_value, input entry_count,
                  input dropped_oldest, input is_empty, output ready);
endinterface

`default_nettype wire

/* rtl/core/overwrite_oldest_event_fifo.sv */
`default_nettype none

// Channel   Dir  Beat contents                                   Handshake
// in_if     in   cmd, value_in                                   valid/ready
// out_if    out  front_value, entry_count, dropped_oldest,       valid/ready
//                is_empty
// apb       in   capacity_limit at byte address 0                psel/penable, pready=1
//
// One command beat per cycle while the status side is not stalling; its status
// beat shows in the output register on the next cycle. The rate rests on the update
// of head, count and the 16-entry register store behind the front-entry mux.
// Reset clears head, count, limit (to DEPTH) and output valid; the store
// is not cleared and needs no sweep. A stalled status beat holds its register;
// a new command is taken in the same cycle the waiting beat leaves.

module overwrite_oldest_event_fifo (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  ooef_cmd_if.sink                              in_if,
  ooef_status_if.source                         out_if,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [ooef_pkg::ADDR_W-1:0]           paddr,
  input  wire  [ooef_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ooef_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int unsigned PTR_W  = ooef_pkg::PTR_W;
  localparam int unsigned CNT_W  = ooef_pkg::CNT_W;
  localparam int unsigned DATA_W = ooef_pkg::DATA_W;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] limit_q;
  logic             cfg_wr;
  logic             cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ooef_pkg::ADDR_W-1:2] == ooef_pkg::REG_CAPACITY_LIMIT);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ooef_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = ooef_pkg::APB_DATA_W'(limit_q);
    end
  end

  // Limits above the store size saturate; storage then overwrites the oldest
  logic [CNT_W-1:0] eff_limit;
  assign eff_limit = (limit_q > CNT_W'(ooef_pkg::DEPTH)) ? CNT_W'(ooef_pkg::DEPTH)
                                                          : limit_q;

  // --------------------------------------------------------------------------
  // Handshake: output register parts the two sides
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic in_acc;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  // --------------------------------------------------------------------------
  // Queue state
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] store_q [ooef_pkg::DEPTH];
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]  tail;
  logic              wr_en;
  logic              drop;
  logic [DATA_W-1:0] front;

  // Count of DEPTH wraps the tail back onto the head, which is what we want
  assign tail = head_q + cnt_q[PTR_W-1:0];

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    wr_en  = 1'b0;
    drop   = 1'b0;
    unique case (ooef_pkg::cmd_e'(in_if.cmd))
      ooef_pkg::CMD_PUSH: begin
        wr_en = 1'b1;
        // Over the limit: advance head past the oldest, count holds
        if ((cnt_q + CNT_W'(1)) > eff_limit) begin
          head_d = head_q + PTR_W'(1);
          drop   = 1'b1;
        end else begin
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      ooef_pkg::CMD_POP: begin
        // Pop on empty does nothing
        if (cnt_q != '0) begin
          head_d = head_q + PTR_W'(1);
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        // Front read, and the unused code, leave the queue as it is
      end
    endcase
  end

  // Front after the operation; forward the pushed value when it lands at head
  always_comb begin
    if (cnt_d == '0) begin
      front = '0;
    end else if (wr_en && (head_d == tail)) begin
      front = in_if.value_in;
    end else begin
      front = store_q[head_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      store_q[tail] <= in_if.value_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else if (in_acc) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Status register
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] front_q;
  logic [CNT_W-1:0]  count_q;
  logic              drop_q;
  logic              empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      front_q <= front;
      count_q <= cnt_d;
      drop_q  <= drop;
      empty_q <= (cnt_d == '0);
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.front_value    = front_q;
  assign out_if.entry_count    = count_q;
  assign out_if.dropped_oldest = drop_q;
  assign out_if.is_empty       = empty_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(ooef_pkg::DEPTH))
    else $error("held count beyond store depth");

  a_drop_only_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_if.cmd != ooef_pkg::CMD_PUSH) |=> !out_if.dropped_oldest)
    else $error("drop flagged on a non-push beat");

  a_empty_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.is_empty |-> (out_if.front_value == '0)
                                        && (out_if.entry_count == '0))
    else $error("empty status beat with nonzero front or count");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_if.valid && (out_if.entry_count == cnt_q))
    else $error("accepted command did not produce a matching status beat");
`endif

endmodule

`default_nettype wire

/* dv/overwrite_oldest_event_fifo_test.sv */
`timescale 1ns / 1ps

module overwrite_oldest_event_fifo_test;
  import ooef_pkg::*;

  // Command code the block leaves unused; it must act as a front read
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  // Cycles to wait for outstanding status beats before calling it lost
  localparam int unsigned DRAIN_LIMIT = 5000;
  // Slots in the ring of owed status beats; far more than can be in flight
  localparam int unsigned OWED_DEPTH = 64;

  typedef struct packed {
    logic [DATA_W-1:0] front;
    logic [CNT_W-1:0]  count;
    logic              dropped;
    logic              empty;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ooef_cmd_if    cmd_if ();
  ooef_status_if status_if ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  overwrite_oldest_event_fifo uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (cmd_if),
    .out_if  (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the queue: circular store, head pointer, fill count, limit
  logic [DATA_W-1:0] shadow_store [DEPTH];
  logic [PTR_W-1:0]  shadow_head;
  logic [CNT_W-1:0]  shadow_count;
  logic [CNT_W-1:0]  shadow_limit;

  // Status beats owed by the block, oldest first, kept in a ring
  status_t     owed_ring [OWED_DEPTH];
  int unsigned owed_wr_cnt;
  int unsigned owed_rd_cnt;

  int unsigned error_count;
  bit          source_gaps_on;
  bit          sink_stalls_on;

  function automatic int unsigned owed_count();
    return owed_wr_cnt - owed_rd_cnt;
  endfunction

  // Apply one command to the shadow queue and return the status it must report.
  function automatic status_t apply_event_cmd(logic [CMD_W-1:0] op, logic [DATA_W-1:0] val);
    status_t          s;
    logic [CNT_W-1:0] eff_limit;
    s = '0;
    // Limits above the store depth saturate to the depth
    eff_limit = (shadow_limit > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : shadow_limit;
    if (op == CMD_PUSH) begin
      // Tail index wraps at DEPTH through the pointer width
      shadow_store[shadow_head + PTR_W'(shadow_count)] = val;
      if (int'(shadow_count) + 1 > int'(eff_limit)) begin
        // Over the limit: advance the head past the oldest entry, count unchanged
        shadow_head = shadow_head + PTR_W'(1);
        s.dropped   = 1'b1;
      end else begin
        shadow_count = shadow_count + CNT_W'(1);
      end
    end else if (op == CMD_POP) begin
      if (shadow_count != '0) begin
        shadow_head  = shadow_head + PTR_W'(1);
        shadow_count = shadow_count - CNT_W'(1);
      end
    end
    // Front reads and the spare code leave the queue alone
    s.count = shadow_count;
    s.empty = (shadow_count == '0);
    s.front = s.empty ? '0 : shadow_store[shadow_head];
    return s;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Event values: plenty of random words plus the corners of the field
  function automatic logic [DATA_W-1:0] pick_event_value();
    logic [DATA_W-1:0] one_hot;
    one_hot = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Lower valid at the accept edge, then hold off for a random gap
  task automatic pace_source();
    int unsigned gap;
    gap = source_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drive one command beat, wait for its handshake, and log the status it owes.
  // Valid stays high when no gap follows, so back-to-back beats see no bubble.
  task automatic send_event_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val);
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd      <= op;
    cmd_if.value_in <= val;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    owed_ring[owed_wr_cnt % OWED_DEPTH] = apply_event_cmd(op, val);
    owed_wr_cnt++;
    pace_source();
  endtask

  // Stop sending and wait until every owed status beat has come back
  task automatic drain_status();
    int unsigned waited;
    waited = 0;
    cmd_if.valid <= 1'b0;
    while (owed_count() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (owed_count() != 0) begin
      error_count++;
      $display("%0t: %0d status beats never arrived", $time, owed_count());
      owed_rd_cnt = owed_wr_cnt;
    end
  endtask

  // Write the limit register while the queue is idle: setup cycle, then access
  task automatic write_capacity_limit(input logic [CNT_W-1:0] lim);
    drain_status();
    repeat (2) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY_LIMIT, 2'b00};
    pwdata  <= APB_DATA_W'(lim);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_limit = lim;
  endtask

  // Empty queue after reset: front read gives zero, pop does nothing,
  // and the spare code reads the front too
  task automatic test_empty_queue();
    send_event_cmd(CMD_READ, 32'hFFFF_FFFF);
    send_event_cmd(CMD_POP, 32'h0);
    send_event_cmd(CMD_SPARE, 32'h1234_5678);
  endtask

  // Fill to the reset limit with corner values, then push once more to drop
  // the oldest entry
  task automatic test_fill_overflow();
    send_event_cmd(CMD_PUSH, 32'hFFFF_FFFF);
    send_event_cmd(CMD_PUSH, 32'h0000_0000);
    send_event_cmd(CMD_PUSH, 32'h8000_0000);
    send_event_cmd(CMD_PUSH, 32'h0000_0001);
    send_event_cmd(CMD_PUSH, 32'hAAAA_5555);
    for (int i = 5; i < DEPTH; i++) send_event_cmd(CMD_PUSH, $urandom);
    send_event_cmd(CMD_PUSH, 32'h5555_AAAA);
    send_event_cmd(CMD_READ, 32'h0);
  endtask

  // Lower the limit under the fill level: the write changes nothing, and a
  // later push drops exactly one entry, so the count holds
  task automatic test_limit_below_count();
    send_event_cmd(CMD_POP, 32'h0);
    write_capacity_limit(CNT_W'(3));
    send_event_cmd(CMD_PUSH, 32'hDEAD_BEEF);
    send_event_cmd(CMD_POP, 32'h0);
  endtask

  // One random stretch under one limit; the push share shifts every 20 beats
  // so the fill level sweeps between empty and full
  task automatic test_random_phase(input logic [CNT_W-1:0] lim, input int unsigned beats);
    int unsigned push_pct;
    int unsigned r;
    push_pct = 50;
    write_capacity_limit(lim);
    source_gaps_on = ($urandom_range(0, 3) != 0);
    sink_stalls_on = ($urandom_range(0, 3) != 0);
    for (int unsigned i = 0; i < beats; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 30;
          1:       push_pct = 55;
          default: push_pct = 80;
        endcase
      end
      // Halfway through, pause until the block has answered everything
      if (i == beats / 2) drain_status();
      r = $urandom_range(0, 99);
      if (r < push_pct)
        send_event_cmd(CMD_PUSH, pick_event_value());
      else if (r < push_pct + 4)
        send_event_cmd(CMD_SPARE, $urandom);
      else if (r < push_pct + 14)
        send_event_cmd(CMD_READ, $urandom);
      else
        send_event_cmd(CMD_POP, $urandom);
    end
  endtask

  // Compare each accepted status beat with the oldest one owed
  always @(posedge clk_i) begin : status_check
    status_t want;
    if (rst_ni && status_if.valid && status_if.ready) begin
      if (owed_count() == 0) begin
        error_count++;
        $display("%0t: status beat with none expected, actual front %0h count %0d",
                 $time, status_if.front_value, status_if.entry_count);
      end else begin
        want = owed_ring[owed_rd_cnt % OWED_DEPTH];
        owed_rd_cnt++;
        if (status_if.front_value !== want.front)
          report_mismatch("front_value", want.front, status_if.front_value);
        if (status_if.entry_count !== want.count)
          report_mismatch("entry_count", DATA_W'(want.count), DATA_W'(status_if.entry_count));
        if (status_if.dropped_oldest !== want.dropped)
          report_mismatch("dropped_oldest", DATA_W'(want.dropped),
                          DATA_W'(status_if.dropped_oldest));
        if (status_if.is_empty !== want.empty)
          report_mismatch("is_empty", DATA_W'(want.empty), DATA_W'(status_if.is_empty));
      end
    end
  end

  // Status-side backpressure: runs of ready, broken by random stalls
  initial begin : sink_pacing
    int unsigned run_len;
    int unsigned hold;
    status_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run_len = $urandom_range(1, 20);
      status_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      hold = sink_stalls_on ? pick_gap() : 0;
      if (hold != 0) begin
        status_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Hard stop in case the block hangs a handshake
  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin : main_sequence
    rst_ni          <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.cmd      <= CMD_READ;
    cmd_if.value_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    error_count     = 0;
    owed_wr_cnt     = 0;
    owed_rd_cnt     = 0;
    source_gaps_on  = 1'b1;
    sink_stalls_on  = 1'b1;
    // Shadow state after reset; the store stays unknown until pushed
    shadow_head     = '0;
    shadow_count    = '0;
    shadow_limit    = LIMIT_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_overflow();
    test_limit_below_count();

    // Limit zero first: pushes drop at once, pops drain what is left
    test_random_phase(CNT_W'(0), 78);
    test_random_phase(CNT_W'(1), 78);
    // Top of the register field saturates to the store depth
    test_random_phase(CNT_W'(31), 78);
    test_random_phase(CNT_W'(DEPTH), 78);
    test_random_phase(CNT_W'($urandom_range(2, DEPTH - 1)), 78);
    test_random_phase(CNT_W'(DEPTH + 1), 78);
    test_random_phase(CNT_W'($urandom_range(2, 6)), 78);
    test_random_phase(CNT_W'(DEPTH), 78);

    drain_status();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
